### rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

### rtl/tcgp_pkg.sv
// Package: sizes, request and register codes, memory entry types.
package tcgp_pkg;
	localparam int FUNCS       = 64;
	localparam int EDGES       = 256;
	localparam int STACK_DEPTH = 32;
	localparam int WORDS       = 16384;

	localparam int PC_W    = 18;
	localparam int CYC_W   = 64;
	localparam int FID_W   = 7;
	localparam int IDX_W   = 14;
	localparam int FA_W    = $clog2(FUNCS);
	localparam int EA_W    = $clog2(EDGES);
	localparam int EC_W    = $clog2(EDGES + 1);
	localparam int SA_W    = $clog2(STACK_DEPTH);
	localparam int DEPTH_W = 6;
	localparam int WA_W    = $clog2(WORDS);
	localparam int REQ_W   = 3;
	localparam int CIDX_W  = 3;
	localparam int CDAT_W  = 7;

	localparam logic [FID_W-1:0] NONE_ID = FID_W'(FUNCS);

	localparam logic [REQ_W-1:0] REQ_LOAD     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RETIRE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FINALIZE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RD_FUNC  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RD_EDGE  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_RD_WORD  = 3'd5;

	localparam logic [CIDX_W-1:0] CFG_COV_EN  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_PROF_EN = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_CG_EN   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_VEC_FN  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_FN_CNT  = 3'd4;

	typedef struct packed {
		logic [PC_W-1:0] start;
		logic [PC_W-1:0] stop;
	} range_t;

	typedef struct packed {
		logic [CYC_W-1:0] calls;
		logic [CYC_W-1:0] cycles;
	} fstat_t;

	typedef struct packed {
		logic             hit;
		logic [CYC_W-1:0] cycles;
	} word_t;

	typedef struct packed {
		logic [FID_W-1:0] caller;
		logic [FID_W-1:0] callee;
		logic [CYC_W-1:0] calls;
		logic [CYC_W-1:0] cycles;
	} edge_t;

	typedef struct packed {
		logic [FID_W-1:0] func;
		logic [FID_W-1:0] caller;
		logic [CYC_W-1:0] entry;
	} frame_t;
endpackage

### rtl/trace_call_graph_profiler_core.sv
// Top level: trace profiler with coverage, word cycles, call stack and edges.
// One item at a time; busy stays high from acceptance until the cycle before
// done; the result is on the ports from the done cycle until the next item is accepted (no stall).
// After reset a clearing pass writes all 16384 word entries, one per cycle,
// with busy high. Loads and unknown requests pass through dispatch to the
// finish state; reads add a wait for the memory output. A retire reads and
// writes its word entry; with profiling or call graph on it then searches the
// range table over min(function_count, 64) entries, one read per entry for both
// PCs, and a push or tail call into a known function updates its call count.
// A pop reads the frame, forms the span and adds it to a known function; with
// the call graph on it searches the edges in use, updates the match or appends one.
// Finalize runs the pop sequence once per open frame.
// All 64-bit sums go through one shared 64-bit adder/subtractor.
module trace_call_graph_profiler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcgp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tcgp_pkg::CDAT_W-1:0]  cfg_data,
	input  logic [tcgp_pkg::REQ_W-1:0]   req_type,
	input  logic [tcgp_pkg::IDX_W-1:0]   index,
	input  logic [tcgp_pkg::PC_W-1:0]    range_start,
	input  logic [tcgp_pkg::PC_W-1:0]    range_end,
	input  logic [tcgp_pkg::PC_W-1:0]    pc_before,
	input  logic [tcgp_pkg::CYC_W-1:0]   cycle_before,
	input  logic [tcgp_pkg::PC_W-1:0]    pc_after,
	input  logic [tcgp_pkg::CYC_W-1:0]   cycle_after,
	input  logic                         is_call,
	input  logic                         is_return,
	output logic [tcgp_pkg::CYC_W-1:0]   count_value,
	output logic [tcgp_pkg::CYC_W-1:0]   cycle_value,
	output logic [tcgp_pkg::FID_W-1:0]   caller_id,
	output logic [tcgp_pkg::FID_W-1:0]   callee_id,
	output logic                         word_hit,
	output logic                         entry_valid,
	output logic [tcgp_pkg::DEPTH_W-1:0] stack_depth
);
	import tcgp_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISP, S_RD_WAIT, S_W_RD, S_W_WR, S_LK_RD, S_LK_CMP,
		S_ACT, S_FC_RD, S_FC_WR, S_POP_RD, S_POP_SPAN, S_PC_RD, S_PC_WR,
		S_E_CHK, S_E_RD, S_E_CMP, S_E_WR1, S_E_WR2, S_POP_END, S_FIN
	} state_t;

	state_t state_q;

	// captured item
	logic [REQ_W-1:0] req_q;
	logic [IDX_W-1:0] idx_q;
	logic [PC_W-1:0]  rs_q, re_q, pcb_q, pca_q;
	logic [CYC_W-1:0] cb_q, ca_q;
	logic             call_q, ret_q;

	// configuration
	logic             cov_en_q, prof_en_q, cg_en_q;
	logic [FID_W-1:0] vf_q, fc_q;

	// working state
	logic [DEPTH_W-1:0] depth_q;
	logic [EC_W-1:0]    edge_used_q, e_q;
	logic [FID_W-1:0]   i_q, callee_q, here_q, pf_q, pcr_q;
	logic [CYC_W-1:0]   span_q, tmp_q;
	logic [WA_W-1:0]    clr_q;
	logic               done_q;

	logic [CYC_W-1:0] cnt_q, cyc_q;
	logic [FID_W-1:0] cr_q, ce_q;
	logic             hit_q, vld_q;

	// memories
	range_t range_mem [FUNCS];
	fstat_t fstat_mem [FUNCS];
	word_t  word_mem  [WORDS];
	edge_t  edge_mem  [EDGES];
	frame_t frame_mem [STACK_DEPTH];

	range_t rng_rd;
	fstat_t fst_rd;
	word_t  wrd_rd;
	edge_t  edg_rd;
	frame_t frm_rd;

	logic            rng_we, rng_re, fst_we, fst_re, wrd_we, wrd_re;
	logic            edg_we, edg_re, frm_we, frm_re;
	logic [FA_W-1:0] rng_addr, fst_addr;
	logic [WA_W-1:0] wrd_addr;
	logic [EA_W-1:0] edg_addr;
	logic [SA_W-1:0] frm_addr;
	range_t          rng_wd;
	fstat_t          fst_wd;
	word_t           wrd_wd;
	edge_t           edg_wd;
	frame_t          frm_wd;

	// shared adder/subtractor
	logic [CYC_W-1:0] alu_a, alu_b, alu_y;
	logic             alu_sub;

	logic [FID_W-1:0]  n_funcs, caller_w;
	logic [PC_W-2:0]   wsel;
	logic              w_ok, track, has_frame, push_c, ret_c, chg_c, room;
	logic              hit_a, hit_b, edge_match;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cfg_ready   = 1'b1;
	assign count_value = cnt_q;
	assign cycle_value = cyc_q;
	assign caller_id   = cr_q;
	assign callee_id   = ce_q;
	assign word_hit    = hit_q;
	assign entry_valid = vld_q;
	assign stack_depth = depth_q;

	assign n_funcs   = (fc_q > NONE_ID) ? NONE_ID : fc_q;
	assign wsel      = pcb_q[PC_W-1:1];
	assign w_ok      = (32'(wsel) < WORDS);
	assign track     = cg_en_q | prof_en_q;
	assign has_frame = (depth_q != '0);
	assign room      = (32'(depth_q) < STACK_DEPTH);
	assign caller_w  = has_frame ? frm_rd.func : here_q;
	assign ret_c     = ret_q & has_frame;
	assign chg_c     = (callee_q != here_q);
	assign push_c    = call_q | (!ret_c & chg_c & (callee_q < NONE_ID) & (callee_q == vf_q));
	assign hit_a     = (pca_q >= rng_rd.start) && (pca_q < rng_rd.stop);
	assign hit_b     = (pcb_q >= rng_rd.start) && (pcb_q < rng_rd.stop);
	assign edge_match = (edg_rd.caller == pcr_q) && (edg_rd.callee == pf_q);

	assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + CYC_W'(alu_sub);

	always_comb begin
		alu_a   = span_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		rng_we = 1'b0; rng_re = 1'b0; rng_addr = idx_q[FA_W-1:0];
		rng_wd = '{start: rs_q, stop: re_q};
		fst_we = 1'b0; fst_re = 1'b0; fst_addr = idx_q[FA_W-1:0];
		fst_wd = '0;
		wrd_we = 1'b0; wrd_re = 1'b0; wrd_addr = wsel[WA_W-1:0];
		wrd_wd = '0;
		edg_we = 1'b0; edg_re = 1'b0; edg_addr = e_q[EA_W-1:0];
		edg_wd = '0;
		frm_we = 1'b0; frm_re = 1'b0; frm_addr = SA_W'(depth_q - 1'b1);
		frm_wd = '0;
		case (state_q)
			S_CLEAR: begin
				wrd_we   = 1'b1;
				wrd_addr = clr_q;
			end
			S_DISP: begin
				case (req_q)
					REQ_LOAD: begin
						if (32'(idx_q) < FUNCS) begin
							rng_we = 1'b1;
							fst_we = 1'b1;
						end
					end
					REQ_RD_FUNC: fst_re = 1'b1;
					REQ_RD_EDGE: begin
						edg_re   = 1'b1;
						edg_addr = idx_q[EA_W-1:0];
					end
					REQ_RD_WORD: begin
						wrd_re   = 1'b1;
						wrd_addr = idx_q[WA_W-1:0];
					end
					default: ;
				endcase
			end
			S_W_RD: begin
				wrd_re  = w_ok;
				alu_a   = ca_q;
				alu_b   = cb_q;
				alu_sub = 1'b1;
			end
			S_W_WR: begin
				alu_a  = wrd_rd.cycles;
				alu_b  = span_q;
				wrd_we = w_ok & (cov_en_q | prof_en_q);
				wrd_wd = '{hit: wrd_rd.hit | cov_en_q,
					cycles: prof_en_q ? alu_y : wrd_rd.cycles};
				frm_re = has_frame;
			end
			S_LK_RD: begin
				rng_re   = (i_q < n_funcs);
				rng_addr = i_q[FA_W-1:0];
			end
			S_ACT: begin
				if (push_c) begin
					frm_we   = room;
					frm_addr = depth_q[SA_W-1:0];
					frm_wd   = '{func: callee_q, caller: caller_w, entry: ca_q};
				end else if (!ret_c && chg_c && has_frame) begin
					frm_we = 1'b1;
					frm_wd = '{func: callee_q, caller: frm_rd.caller, entry: frm_rd.entry};
				end
			end
			S_FC_RD: begin
				fst_re   = 1'b1;
				fst_addr = callee_q[FA_W-1:0];
			end
			S_FC_WR: begin
				alu_a    = fst_rd.calls;
				alu_b    = CYC_W'(1);
				fst_we   = 1'b1;
				fst_addr = callee_q[FA_W-1:0];
				fst_wd   = '{calls: alu_y, cycles: fst_rd.cycles};
			end
			S_POP_RD: frm_re = 1'b1;
			S_POP_SPAN: begin
				alu_a   = ca_q;
				alu_b   = frm_rd.entry;
				alu_sub = 1'b1;
			end
			S_PC_RD: begin
				fst_re   = 1'b1;
				fst_addr = pf_q[FA_W-1:0];
			end
			S_PC_WR: begin
				alu_a    = fst_rd.cycles;
				alu_b    = span_q;
				fst_we   = 1'b1;
				fst_addr = pf_q[FA_W-1:0];
				fst_wd   = '{calls: fst_rd.calls, cycles: alu_y};
			end
			S_E_RD: begin
				if (e_q < edge_used_q) begin
					edg_re = 1'b1;
				end else if (32'(edge_used_q) < EDGES) begin
					edg_we = 1'b1;
					edg_wd = '{caller: pcr_q, callee: pf_q,
						calls: CYC_W'(req_q == REQ_RETIRE), cycles: span_q};
				end
			end
			S_E_WR1: begin
				alu_a = edg_rd.calls;
				alu_b = CYC_W'(req_q == REQ_RETIRE);
			end
			S_E_WR2: begin
				alu_a  = edg_rd.cycles;
				alu_b  = span_q;
				edg_we = 1'b1;
				edg_wd = '{caller: pcr_q, callee: pf_q, calls: tmp_q, cycles: alu_y};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rng_we) range_mem[rng_addr] <= rng_wd;
		if (rng_re) rng_rd <= range_mem[rng_addr];
	end

	always_ff @(posedge clk) begin
		if (fst_we) fstat_mem[fst_addr] <= fst_wd;
		if (fst_re) fst_rd <= fstat_mem[fst_addr];
	end

	always_ff @(posedge clk) begin
		if (wrd_we) word_mem[wrd_addr] <= wrd_wd;
		if (wrd_re) wrd_rd <= word_mem[wrd_addr];
	end

	always_ff @(posedge clk) begin
		if (edg_we) edge_mem[edg_addr] <= edg_wd;
		if (edg_re) edg_rd <= edge_mem[edg_addr];
	end

	always_ff @(posedge clk) begin
		if (frm_we) frame_mem[frm_addr] <= frm_wd;
		if (frm_re) frm_rd <= frame_mem[frm_addr];
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q  <= req_type;
			idx_q  <= index;
			rs_q   <= range_start;
			re_q   <= range_end;
			pcb_q  <= pc_before;
			pca_q  <= pc_after;
			cb_q   <= cycle_before;
			ca_q   <= cycle_after;
			call_q <= is_call;
			ret_q  <= is_return;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cov_en_q    <= 1'b0;
			prof_en_q   <= 1'b0;
			cg_en_q     <= 1'b0;
			vf_q        <= NONE_ID;
			fc_q        <= '0;
			depth_q     <= '0;
			edge_used_q <= '0;
			e_q         <= '0;
			i_q         <= '0;
			callee_q    <= NONE_ID;
			here_q      <= NONE_ID;
			pf_q        <= NONE_ID;
			pcr_q       <= NONE_ID;
			span_q      <= '0;
			tmp_q       <= '0;
			clr_q       <= '0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			cyc_q       <= '0;
			cr_q        <= NONE_ID;
			ce_q        <= NONE_ID;
			hit_q       <= 1'b0;
			vld_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_COV_EN:  cov_en_q  <= cfg_data[0];
					CFG_PROF_EN: prof_en_q <= cfg_data[0];
					CFG_CG_EN:   cg_en_q   <= cfg_data[0];
					CFG_VEC_FN:  vf_q      <= cfg_data;
					CFG_FN_CNT:  fc_q      <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == WORDS - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						cyc_q   <= '0;
						cr_q    <= NONE_ID;
						ce_q    <= NONE_ID;
						hit_q   <= 1'b0;
						vld_q   <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (req_q)
						REQ_RETIRE:   state_q <= S_W_RD;
						REQ_FINALIZE: state_q <= has_frame ? S_POP_RD : S_FIN;
						REQ_RD_FUNC,
						REQ_RD_EDGE,
						REQ_RD_WORD:  state_q <= S_RD_WAIT;
						default:      state_q <= S_FIN;
					endcase
				end
				S_RD_WAIT: begin
					case (req_q)
						REQ_RD_FUNC: begin
							if (idx_q < IDX_W'(n_funcs)) begin
								cnt_q <= fst_rd.calls;
								cyc_q <= fst_rd.cycles;
								vld_q <= 1'b1;
							end
						end
						REQ_RD_EDGE: begin
							if (idx_q < IDX_W'(edge_used_q)) begin
								cnt_q <= edg_rd.calls;
								cyc_q <= edg_rd.cycles;
								cr_q  <= edg_rd.caller;
								ce_q  <= edg_rd.callee;
								vld_q <= 1'b1;
							end
						end
						default: begin
							hit_q <= wrd_rd.hit;
							cyc_q <= wrd_rd.cycles;
							vld_q <= 1'b1;
						end
					endcase
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_W_RD: begin
					span_q  <= alu_y;
					state_q <= S_W_WR;
				end
				S_W_WR: begin
					i_q      <= '0;
					callee_q <= NONE_ID;
					here_q   <= NONE_ID;
					state_q  <= track ? S_LK_RD : S_FIN;
				end
				S_LK_RD: state_q <= (i_q < n_funcs) ? S_LK_CMP : S_ACT;
				S_LK_CMP: begin
					// first match wins
					if (callee_q == NONE_ID && hit_a) callee_q <= i_q;
					if (here_q == NONE_ID && hit_b) here_q <= i_q;
					i_q     <= i_q + 1'b1;
					state_q <= S_LK_RD;
				end
				S_ACT: begin
					if (push_c) begin
						if (room) begin
							depth_q <= depth_q + 1'b1;
							state_q <= (callee_q < NONE_ID) ? S_FC_RD : S_FIN;
						end else begin
							state_q <= S_FIN;
						end
					end else if (ret_c) begin
						state_q <= S_POP_RD;
					end else if (chg_c && has_frame) begin
						// tail call: top frame now belongs to the new function
						state_q <= (callee_q < NONE_ID) ? S_FC_RD : S_FIN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FC_RD: state_q <= S_FC_WR;
				S_FC_WR: state_q <= S_FIN;
				S_POP_RD: begin
					depth_q <= depth_q - 1'b1;
					state_q <= S_POP_SPAN;
				end
				S_POP_SPAN: begin
					span_q  <= alu_y;
					pf_q    <= frm_rd.func;
					pcr_q   <= frm_rd.caller;
					state_q <= (frm_rd.func < NONE_ID) ? S_PC_RD : S_E_CHK;
				end
				S_PC_RD: state_q <= S_PC_WR;
				S_PC_WR: state_q <= S_E_CHK;
				S_E_CHK: begin
					e_q     <= '0;
					state_q <= (cg_en_q && pf_q < NONE_ID && pcr_q < NONE_ID) ?
						S_E_RD : S_POP_END;
				end
				S_E_RD: begin
					if (e_q < edge_used_q) begin
						state_q <= S_E_CMP;
					end else begin
						if (32'(edge_used_q) < EDGES) edge_used_q <= edge_used_q + 1'b1;
						state_q <= S_POP_END;
					end
				end
				S_E_CMP: begin
					if (edge_match) begin
						state_q <= S_E_WR1;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_E_RD;
					end
				end
				S_E_WR1: begin
					tmp_q   <= alu_y;
					state_q <= S_E_WR2;
				end
				S_E_WR2: state_q <= S_POP_END;
				S_POP_END: begin
					state_q <= (req_q == REQ_FINALIZE && has_frame) ? S_POP_RD : S_FIN;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/tcgp_chk.sv
// Port-level checker for the profiler core, with its bind.
`include "assert_macros.svh"

module tcgp_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [tcgp_pkg::DEPTH_W-1:0] stack_depth
);
	import tcgp_pkg::*;

	`AST_NEXT(a_accept_busy, start && !busy, busy)
	`AST_IMPL(a_done_idle, done, !busy)
	`AST_NEXT(a_done_single, done, !done)
	`AST_IMPL(a_depth_max, done, 32'(stack_depth) <= STACK_DEPTH)
endmodule

bind trace_call_graph_profiler_core tcgp_chk u_tcgp_chk (.*);

### bench/tcgp_checker.sv
// Checker for the trace profiler: predicts every result and compares it.
module tcgp_checker
	import tcgp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 done,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CIDX_W-1:0]    cfg_index,
	input  logic [CDAT_W-1:0]    cfg_data,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [IDX_W-1:0]     index,
	input  logic [PC_W-1:0]      range_start,
	input  logic [PC_W-1:0]      range_end,
	input  logic [PC_W-1:0]      pc_before,
	input  logic [CYC_W-1:0]     cycle_before,
	input  logic [PC_W-1:0]      pc_after,
	input  logic [CYC_W-1:0]     cycle_after,
	input  logic                 is_call,
	input  logic                 is_return,
	input  logic [CYC_W-1:0]     count_value,
	input  logic [CYC_W-1:0]     cycle_value,
	input  logic [FID_W-1:0]     caller_id,
	input  logic [FID_W-1:0]     callee_id,
	input  logic                 word_hit,
	input  logic                 entry_valid,
	input  logic [DEPTH_W-1:0]   stack_depth,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CYC_W-1:0]   count;
		logic [CYC_W-1:0]   cycles;
		logic [FID_W-1:0]   caller;
		logic [FID_W-1:0]   callee;
		logic               hit;
		logic               valid;
		logic [DEPTH_W-1:0] depth;
	} answer_t;

	answer_t answers_q[$];

	logic cov_en, prof_en, cg_en;
	logic [FID_W-1:0] vec_fn, fn_cnt;

	logic [PC_W-1:0]  fn_lo[FUNCS], fn_hi[FUNCS];
	logic [CYC_W-1:0] fn_calls[FUNCS], fn_cyc[FUNCS];
	logic             wd_hit[WORDS];
	logic [CYC_W-1:0] wd_cyc[WORDS];
	logic [FID_W-1:0] eg_caller[EDGES], eg_callee[EDGES];
	logic [CYC_W-1:0] eg_calls[EDGES], eg_cyc[EDGES];
	int               eg_used;
	logic [FID_W-1:0] st_func[STACK_DEPTH], st_caller[STACK_DEPTH];
	logic [CYC_W-1:0] st_entry[STACK_DEPTH];
	int               depth;

	function automatic logic [FID_W-1:0] func_of(logic [PC_W-1:0] pc);
		int n;
		n = (fn_cnt > FUNCS) ? FUNCS : fn_cnt;
		for (int i = 0; i < n; i++)
			if (pc >= fn_lo[i] && pc < fn_hi[i])
				return FID_W'(i);
		return NONE_ID;
	endfunction

	task automatic push_frame(logic [FID_W-1:0] f, logic [FID_W-1:0] c, logic [CYC_W-1:0] t);
		if (depth < STACK_DEPTH) begin
			st_func[depth] = f;
			st_caller[depth] = c;
			st_entry[depth] = t;
			depth++;
			if (f < NONE_ID)
				fn_calls[f] += 1;
		end
	endtask

	task automatic pop_frame(logic [CYC_W-1:0] t, bit real_return);
		logic [FID_W-1:0] f, c;
		logic [CYC_W-1:0] span;
		int e;
		depth--;
		f = st_func[depth];
		c = st_caller[depth];
		span = t - st_entry[depth];
		if (f < NONE_ID)
			fn_cyc[f] += span;
		if (!cg_en || f >= NONE_ID || c >= NONE_ID)
			return;
		for (e = 0; e < eg_used; e++)
			if (eg_caller[e] == c && eg_callee[e] == f)
				break;
		if (e == eg_used) begin
			if (eg_used >= EDGES)
				return;
			eg_caller[e] = c;
			eg_callee[e] = f;
			eg_calls[e] = '0;
			eg_cyc[e] = '0;
			eg_used++;
		end
		if (real_return)
			eg_calls[e] += 1;
		eg_cyc[e] += span;
	endtask

	task automatic retire_step();
		logic [PC_W-2:0] w;
		logic [FID_W-1:0] callee, here, caller;
		w = pc_before[PC_W-1:1];
		if (cov_en && w < WORDS)
			wd_hit[w] = 1'b1;
		if (prof_en && w < WORDS)
			wd_cyc[w] += cycle_after - cycle_before;
		if (!cg_en && !prof_en)
			return;
		callee = func_of(pc_after);
		here = func_of(pc_before);
		caller = (depth > 0) ? st_func[depth-1] : here;
		if (is_call) begin
			push_frame(callee, caller, cycle_after);
		end else if (is_return && depth > 0) begin
			pop_frame(cycle_after, 1'b1);
		end else if (callee != here) begin
			if (callee < NONE_ID && callee == vec_fn) begin
				push_frame(callee, caller, cycle_after);
			end else if (depth > 0) begin
				// tail call: top frame changes function
				st_func[depth-1] = callee;
				if (callee < NONE_ID)
					fn_calls[callee] += 1;
			end
		end
	endtask

	task automatic predict_item();
		answer_t a;
		a = '{default: '0};
		a.caller = NONE_ID;
		a.callee = NONE_ID;
		case (req_type)
			REQ_LOAD: begin
				if (index < FUNCS) begin
					fn_lo[index] = range_start;
					fn_hi[index] = range_end;
					fn_calls[index] = '0;
					fn_cyc[index] = '0;
				end
			end
			REQ_RETIRE: retire_step();
			REQ_FINALIZE: begin
				while (depth > 0)
					pop_frame(cycle_after, 1'b0);
			end
			REQ_RD_FUNC: begin
				if (index < ((fn_cnt > FUNCS) ? FUNCS : fn_cnt)) begin
					a.count = fn_calls[index];
					a.cycles = fn_cyc[index];
					a.valid = 1'b1;
				end
			end
			REQ_RD_EDGE: begin
				if (index < eg_used) begin
					a.count = eg_calls[index];
					a.cycles = eg_cyc[index];
					a.caller = eg_caller[index];
					a.callee = eg_callee[index];
					a.valid = 1'b1;
				end
			end
			REQ_RD_WORD: begin
				if (index < WORDS) begin
					a.hit = wd_hit[index];
					a.cycles = wd_cyc[index];
					a.valid = 1'b1;
				end
			end
			default: ;
		endcase
		a.depth = DEPTH_W'(depth);
		answers_q.push_back(a);
	endtask

	task automatic check_result();
		answer_t a;
		if (answers_q.size() == 0) begin
			$error("result with no item outstanding");
			errors++;
			return;
		end
		a = answers_q.pop_front();
		if (count_value !== a.count) begin
			$error("count_value exp %h got %h", a.count, count_value); errors++;
		end
		if (cycle_value !== a.cycles) begin
			$error("cycle_value exp %h got %h", a.cycles, cycle_value); errors++;
		end
		if (caller_id !== a.caller) begin
			$error("caller_id exp %h got %h", a.caller, caller_id); errors++;
		end
		if (callee_id !== a.callee) begin
			$error("callee_id exp %h got %h", a.callee, callee_id); errors++;
		end
		if (word_hit !== a.hit) begin
			$error("word_hit exp %h got %h", a.hit, word_hit); errors++;
		end
		if (entry_valid !== a.valid) begin
			$error("entry_valid exp %h got %h", a.valid, entry_valid); errors++;
		end
		if (stack_depth !== a.depth) begin
			$error("stack_depth exp %h got %h", a.depth, stack_depth); errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			answers_q.delete();
			cov_en = 0; prof_en = 0; cg_en = 0;
			vec_fn = NONE_ID;
			fn_cnt = '0;
			for (int i = 0; i < FUNCS; i++) begin
				fn_lo[i] = '0; fn_hi[i] = '0; fn_calls[i] = '0; fn_cyc[i] = '0;
			end
			for (int i = 0; i < WORDS; i++) begin
				wd_hit[i] = 0; wd_cyc[i] = '0;
			end
			eg_used = 0;
			depth = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COV_EN:  cov_en = cfg_data[0];
					CFG_PROF_EN: prof_en = cfg_data[0];
					CFG_CG_EN:   cg_en = cfg_data[0];
					CFG_VEC_FN:  vec_fn = cfg_data;
					CFG_FN_CNT:  fn_cnt = cfg_data;
					default: ;
				endcase
			end
			if (done)
				check_result();
			if (start && !busy)
				predict_item();
			pending <= answers_q.size();
		end
	end
endmodule

### bench/trace_call_graph_profiler_core_tb.sv
// Testbench top: drives requests and configuration, reports the verdict.
module trace_call_graph_profiler_core_tb;
	import tcgp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic clk, arst_n, start, busy, done;
	logic cfg_valid, cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CDAT_W-1:0] cfg_data;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] index;
	logic [PC_W-1:0] range_start, range_end, pc_before, pc_after;
	logic [CYC_W-1:0] cycle_before, cycle_after;
	logic is_call, is_return;
	logic [CYC_W-1:0] count_value, cycle_value;
	logic [FID_W-1:0] caller_id, callee_id;
	logic word_hit, entry_valid;
	logic [DEPTH_W-1:0] stack_depth;
	int errors, pending;
	longint cycles_run;

	trace_call_graph_profiler_core dut (.*);
	tcgp_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("trace_call_graph_profiler_core_tb: done, errors");
			$finish;
		end
	end

	// program counter and time of the simulated trace
	logic [PC_W-1:0] trace_pc;
	logic [CYC_W-1:0] trace_time;
	int burst_left;
	bit no_gaps;
	int cur_fcnt;

	// start stays high after the accepting edge; the next item, a gap or
	// wait_idle decides its next value
	task automatic send(logic [REQ_W-1:0] rq, logic [IDX_W-1:0] ix = '0,
			logic [PC_W-1:0] rs = '0, logic [PC_W-1:0] re = '0,
			logic [PC_W-1:0] pb = '0, logic [CYC_W-1:0] cb = '0,
			logic [PC_W-1:0] pa = '0, logic [CYC_W-1:0] ca = '0,
			logic call = 0, logic ret = 0);
		if (!no_gaps && burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		req_type <= rq; index <= ix; range_start <= rs; range_end <= re;
		pc_before <= pb; cycle_before <= cb; pc_after <= pa; cycle_after <= ca;
		is_call <= call; is_return <= ret;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] ri, logic [CDAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(bit cv, bit pf, bit cg, logic [6:0] vf, logic [6:0] fc);
		wait_idle();
		write_reg(CFG_COV_EN, {6'd0, cv});
		write_reg(CFG_PROF_EN, {6'd0, pf});
		write_reg(CFG_CG_EN, {6'd0, cg});
		write_reg(CFG_VEC_FN, vf);
		write_reg(CFG_FN_CNT, fc);
		cfg_valid <= 1'b0;
		cur_fcnt = (fc > FUNCS) ? FUNCS : fc;
	endtask

	function automatic logic [PC_W-1:0] fn_base(int f);
		return PC_W'(f * 4096);
	endfunction

	task automatic random_retire(int call_pct);
		logic [PC_W-1:0] pa;
		logic [CYC_W-1:0] cb, ca;
		int r, k, tgt;
		bit c, rt;
		r = $urandom_range(0, 99);
		tgt = $urandom_range(0, (cur_fcnt > 0) ? cur_fcnt - 1 : 3);
		k = $urandom_range(0, 99);
		c = (k < call_pct);
		rt = !c && k < call_pct + 25 || k >= 97;
		if (c || r < 30)
			pa = fn_base(tgt) + PC_W'(2 * $urandom_range(0, 40));
		else if (r < 90)
			pa = trace_pc + 18'd2;
		else
			pa = PC_W'($urandom);
		cb = trace_time;
		ca = cb + CYC_W'($urandom_range(1, 50));
		if ($urandom_range(0, 99) < 3) begin
			cb = {$urandom, $urandom};
			ca = {$urandom, $urandom};
		end
		send(REQ_RETIRE, IDX_W'($urandom), '0, '0, trace_pc, cb, pa, ca, c, rt);
		trace_pc = pa;
		trace_time = ca;
	endtask

	task automatic random_item(int call_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			random_retire(call_pct);
		else if (r < 72)
			send(REQ_RD_FUNC, ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
				: IDX_W'($urandom_range(0, 70)));
		else if (r < 80)
			send(REQ_RD_EDGE, ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
				: IDX_W'($urandom_range(0, 270)));
		else if (r < 88)
			send(REQ_RD_WORD, ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
				: IDX_W'((trace_pc >> 1) - $urandom_range(0, 8)));
		else if (r < 91)
			send(REQ_FINALIZE, IDX_W'($urandom), '0, '0, '0, '0, '0, trace_time);
		else if (r < 93)
			send(REQ_LOAD, ($urandom_range(0, 1)) ? IDX_W'($urandom_range(0, 63))
				: IDX_W'($urandom), PC_W'($urandom), PC_W'($urandom));
		else if (r < 95)
			send(REQ_LOAD, IDX_W'($urandom_range(0, 63)),
				fn_base($urandom_range(0, 63)), fn_base($urandom_range(0, 63)) + 18'd2048);
		else if (r < 97)
			send(($urandom_range(0, 1)) ? 3'd6 : 3'd7, IDX_W'($urandom), PC_W'($urandom),
				PC_W'($urandom), PC_W'($urandom), {$urandom, $urandom}, PC_W'($urandom),
				{$urandom, $urandom}, 1'($urandom), 1'($urandom));
		else
			random_retire(call_pct);
	endtask

	initial begin
		start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		req_type = '0; index = '0; range_start = '0; range_end = '0;
		pc_before = '0; cycle_before = '0; pc_after = '0; cycle_after = '0;
		is_call = 0; is_return = 0;
		cycles_run = 0;
		trace_pc = 18'h100;
		trace_time = 64'd1000;
		burst_left = 0;
		no_gaps = 0;
		cur_fcnt = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// every table entry gets a range before any search can reach it
		for (int f = 0; f < FUNCS; f++)
			send(REQ_LOAD, IDX_W'(f), fn_base(f), fn_base(f) + 18'd2048);

		configure(1, 1, 1, 7'd3, 7'd8);
		send(REQ_RETIRE, '0, '0, '0, 18'h3FFFF, 64'd5, 18'h0010, 64'd9);
		send(REQ_RETIRE, '0, '0, '0, 18'h0010, 64'd10, fn_base(1), 64'd20, 1, 0);
		send(REQ_RETIRE, '0, '0, '0, fn_base(1), 64'd20, fn_base(2), 64'd30, 1, 0);
		send(REQ_RETIRE, '0, '0, '0, fn_base(2), 64'd30, fn_base(1) + 4, 64'd45, 0, 1);
		send(REQ_RETIRE, '0, '0, '0, fn_base(1) + 4, 64'd45, fn_base(5), 64'd50);
		send(REQ_RETIRE, '0, '0, '0, fn_base(5), 64'd50, fn_base(3), 64'd55);
		send(REQ_RETIRE, '0, '0, '0, fn_base(3), 64'd55, fn_base(4), 64'd60, 1, 1);
		send(REQ_RETIRE, '0, '0, '0, fn_base(4), '1, fn_base(4) + 2, 64'd3);
		send(REQ_RETIRE, '0, '0, '0, fn_base(9) + 18'd3000, 64'd70, fn_base(2), 64'd71);
		send(REQ_RD_FUNC, 14'd1);
		send(REQ_RD_FUNC, 14'd63);
		send(REQ_RD_EDGE, 14'd0);
		send(REQ_RD_EDGE, 14'd255);
		send(REQ_RD_WORD, 14'd0);
		send(REQ_RD_WORD, 14'h3FFF);
		send(3'd6, 14'h3FFF, '1, '1, '1, '1, '1, '1, 1, 1);
		send(3'd7);
		send(REQ_FINALIZE, '0, '0, '0, '0, '0, '0, 64'd500);
		send(REQ_RD_EDGE, 14'd1);
		send(REQ_LOAD, 14'h3FFF, '1, '1);
		send(REQ_LOAD, 14'd6, fn_base(2), fn_base(3));
		send(REQ_RETIRE, '0, '0, '0, 18'h0010, 64'd600, fn_base(2) + 8, 64'd610, 1, 0);
		send(REQ_RD_FUNC, 14'd2);
		send(REQ_FINALIZE, '0, '0, '0, '0, '0, '0, '1);
		send(REQ_RD_FUNC, 14'd2);

		// several settings, extremes among them; one phase with a call-heavy trace
		for (int ph = 0; ph < 7; ph++) begin
			int n, callp;
			no_gaps = (ph == 2 || ph == 5);
			n = 230;
			callp = 20;
			case (ph)
				0: configure(1, 1, 1, 7'd5, 7'd8);
				1: configure(0, 1, 0, 7'd64, 7'd16);
				2: begin configure(1, 0, 1, 7'd0, 7'd64); n = 80; end
				3: configure(0, 0, 0, 7'd64, 7'd0);
				4: begin configure(1, 1, 1, 7'd2, 7'd127); n = 80; end
				5: begin configure(1, 0, 1, 7'd7, 7'd12); callp = 60; end
				default: configure(1, 1, 1, 7'd1, 7'd32);
			endcase
			for (int i = 0; i < n; i++)
				random_item(callp);
			send(REQ_FINALIZE, '0, '0, '0, '0, '0, '0, trace_time);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("trace_call_graph_profiler_core_tb: done, clean");
		else
			$display("trace_call_graph_profiler_core_tb: done, errors");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/tcgp_pkg.sv
rtl/trace_call_graph_profiler_core.sv
rtl/tcgp_chk.sv
bench/tcgp_checker.sv
bench/trace_call_graph_profiler_core_tb.sv
